[rtl/acpd_pkg.sv]
// ----------------------------------------------------------------------------
// acpd_pkg
// Types, command codes and reply tables shared by the packet device modules.
// ----------------------------------------------------------------------------
package acpd_pkg;

   localparam logic [2:0] MODE_RESET  = 3'd0;
   localparam logic [2:0] MODE_BEGIN  = 3'd1;
   localparam logic [2:0] MODE_PACKET = 3'd2;
   localparam logic [2:0] MODE_READ   = 3'd3;
   localparam logic [2:0] MODE_MEDIA  = 3'd4;
   localparam logic [2:0] MODE_CLEAR  = 3'd5;

   localparam logic [7:0] OP_TEST_READY = 8'h00;
   localparam logic [7:0] OP_SENSE      = 8'h03;
   localparam logic [7:0] OP_INQUIRY    = 8'h12;
   localparam logic [7:0] OP_CAPACITY   = 8'h25;
   localparam logic [7:0] OP_READ10     = 8'h28;

   localparam logic [7:0] KEY_NOT_READY = 8'h02;
   localparam logic [7:0] KEY_ILLEGAL   = 8'h05;
   localparam logic [7:0] ASC_NO_MEDIUM = 8'h3A;
   localparam logic [7:0] ASC_RANGE     = 8'h21;
   localparam logic [7:0] ASC_OPCODE    = 8'h20;

   localparam logic [7:0] STATUS_DRQ  = 8'h08;
   localparam logic [7:0] STATUS_DRDY = 8'h40;

   localparam logic [2:0] PH_CODE_IDLE   = 3'd0;
   localparam logic [2:0] PH_CODE_PACKET = 3'd1;
   localparam logic [2:0] PH_CODE_FETCH  = 3'd2;
   localparam logic [2:0] PH_CODE_DATA   = 3'd3;
   localparam logic [2:0] PH_CODE_STATUS = 3'd4;

   localparam int SECTOR_BYTES = 2048;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_PACKET = 5'b00010,
      PH_FETCH  = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_STATUS = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      SRC_BUF   = 2'd0,
      SRC_INQ   = 2'd1,
      SRC_SENSE = 2'd2,
      SRC_CAP   = 2'd3
   } src_type;

   typedef struct packed {
      logic        we;
      logic        re;
   } ram_ctl_type;

   typedef struct packed {
      logic [15:0] read_word;
      logic        use_ram;
      logic        accepted;
      logic [7:0]  status_byte;
      logic        error_flag;
      logic [2:0]  phase_now;
      logic [13:0] bytes_left;
      logic        disc_changed;
      logic        fetch_request;
      logic [31:0] fetch_lba;
      logic [15:0] fetch_count;
   } result_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] c;
      case (ph)
         PH_PACKET: c = PH_CODE_PACKET;
         PH_FETCH:  c = PH_CODE_FETCH;
         PH_DATA:   c = PH_CODE_DATA;
         PH_STATUS: c = PH_CODE_STATUS;
         default:   c = PH_CODE_IDLE;
      endcase
      return c;
   endfunction

   // Identification reply, two bytes to a word, high byte first.
   function automatic logic [15:0] inquiry_word(input logic [4:0] idx);
      logic [15:0] w;
      case (idx)
         5'd0:    w = 16'h0580;
         5'd1:    w = 16'h0021;
         5'd2:    w = 16'h1F00;
         5'd3:    w = 16'h0000;
         5'd4:    w = 16'h4245;
         5'd5:    w = 16'h4C4C;
         5'd6:    w = 16'h4154;
         5'd7:    w = 16'h5249;
         5'd8:    w = 16'h5649;
         5'd9:    w = 16'h5254;
         5'd10:   w = 16'h5541;
         5'd11:   w = 16'h4C20;
         5'd12:   w = 16'h4344;
         5'd13:   w = 16'h2D52;
         5'd14:   w = 16'h4F4D;
         default: w = 16'h0000;
      endcase
      return w;
   endfunction

endpackage

[rtl/acpd_ram.sv]
// ----------------------------------------------------------------------------
// acpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/acpd_core.sv]
// ----------------------------------------------------------------------------
// acpd_core
// Command state, packet collection and decode; one item handled per cycle while accept is high.
// ----------------------------------------------------------------------------
module acpd_core #(
   parameter int BUFFER_SECTORS = 4,
   parameter int PACKET_BYTES   = 12,
   parameter int ADDR_W         = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [2:0]            mode,
   input  logic [15:0]           word_in,
   input  logic                  media_present,
   input  logic [31:0]           sector_count,
   input  logic [13:0]           capacity_bytes,
   output acpd_pkg::result_type  result,
   output acpd_pkg::ram_ctl_type ram_ctl,
   output logic [ADDR_W-1:0]     ram_waddr,
   output logic [ADDR_W-1:0]     ram_raddr
);
   import acpd_pkg::*;

   localparam int FILL_W = $clog2(PACKET_BYTES + 2);
   localparam logic [31:0] BUF_BYTES = 32'(BUFFER_SECTORS * SECTOR_BYTES);

   phase_type         phase_ff, phase_in;
   src_type           src_ff, src_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        pkt_ff [PACKET_BYTES];
   logic [7:0]        pkt_in [PACKET_BYTES];
   logic [14:0]       rlen_ff, rlen_in, rpos_ff, rpos_in, fpos_ff, fpos_in;
   logic [7:0]        key_ff, key_in, asc_ff, asc_in, ascq_ff, ascq_in;
   logic              chg_ff, chg_in;
   logic [31:0]       last_ff, last_in;

   logic [31:0] lba;
   logic [15:0] count;
   logic [26:0] total;
   logic [31:0] cap_lim;
   logic        too_big, range_bad;
   logic [FILL_W-1:0] fill_next;
   logic [4:0]  widx;
   logic [15:0] const_word;

   assign lba     = {pkt_ff[2], pkt_ff[3], pkt_ff[4], pkt_ff[5]};
   assign count   = {pkt_ff[7], pkt_ff[8]};
   assign total   = {count, 11'b0};
   assign cap_lim = ({18'b0, capacity_bytes} < BUF_BYTES) ? {18'b0, capacity_bytes}
                                                         : BUF_BYTES;
   assign too_big   = {5'b0, total} > cap_lim;
   assign range_bad = ({1'b0, lba} + {17'b0, count}) > {1'b0, sector_count};
   assign fill_next = fill_ff + FILL_W'(2);
   assign widx      = rpos_ff[5:1];

   always_comb begin
      case (src_ff)
         SRC_INQ: const_word = inquiry_word(widx);
         SRC_SENSE: begin
            case (widx)
               5'd0:    const_word = 16'h7000;
               5'd1:    const_word = {key_ff, 8'h00};
               5'd3:    const_word = 16'h000A;
               5'd6:    const_word = {asc_ff, ascq_ff};
               default: const_word = 16'h0000;
            endcase
         end
         SRC_CAP: begin
            case (widx)
               5'd0:    const_word = last_ff[31:16];
               5'd1:    const_word = last_ff[15:0];
               5'd3:    const_word = 16'(SECTOR_BYTES);
               default: const_word = 16'h0000;
            endcase
         end
         default: const_word = 16'h0000;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      src_in   = src_ff;
      fill_in  = fill_ff;
      pkt_in   = pkt_ff;
      rlen_in  = rlen_ff;
      rpos_in  = rpos_ff;
      fpos_in  = fpos_ff;
      key_in   = key_ff;
      asc_in   = asc_ff;
      ascq_in  = ascq_ff;
      chg_in   = chg_ff;
      last_in  = last_ff;
      result   = '0;
      ram_ctl  = '0;
      ram_waddr = ADDR_W'(fpos_ff >> 1);
      ram_raddr = ADDR_W'(rpos_ff >> 1);

      if (accept) begin
         case (mode)
            MODE_RESET: begin
               phase_in = PH_IDLE;
               fill_in  = '0;
               rlen_in  = '0;
               rpos_in  = '0;
               fpos_in  = '0;
               key_in   = '0;
               asc_in   = '0;
               ascq_in  = '0;
               chg_in   = 1'b1;
            end
            MODE_BEGIN: begin
               phase_in = PH_PACKET;
               fill_in  = '0;
            end
            MODE_PACKET: begin
               if (phase_ff == PH_PACKET) begin
                  result.accepted = 1'b1;
                  for (int i = 0; i < PACKET_BYTES; i++) begin
                     if (FILL_W'(i) == fill_ff) begin
                        pkt_in[i] = word_in[15:8];
                     end
                     if (FILL_W'(i) == fill_ff + FILL_W'(1)) begin
                        pkt_in[i] = word_in[7:0];
                     end
                  end
                  fill_in = fill_next;
                  if (fill_next >= FILL_W'(PACKET_BYTES)) begin
                     fill_in = '0;
                     // The decoded bytes all lie ahead of the final word.
                     case (pkt_ff[0])
                        OP_INQUIRY: begin
                           src_in = SRC_INQ;   rlen_in = 15'd36;
                           rpos_in = '0;       phase_in = PH_DATA;
                        end
                        OP_SENSE: begin
                           src_in = SRC_SENSE; rlen_in = 15'd18;
                           rpos_in = '0;       phase_in = PH_DATA;
                        end
                        OP_CAPACITY: begin
                           src_in = SRC_CAP;   rlen_in = 15'd8;
                           rpos_in = '0;       phase_in = PH_DATA;
                           last_in = sector_count - 32'd1;
                        end
                        OP_TEST_READY: begin
                           if (!media_present) begin
                              key_in = KEY_NOT_READY; asc_in = ASC_NO_MEDIUM;
                              ascq_in = 8'h00;
                           end
                           phase_in = PH_STATUS;
                        end
                        OP_READ10: begin
                           if (too_big || !media_present || range_bad) begin
                              key_in = KEY_ILLEGAL; asc_in = ASC_RANGE; ascq_in = 8'h00;
                              phase_in = PH_STATUS;
                           end else if (count == 16'd0) begin
                              phase_in = PH_STATUS;
                           end else begin
                              src_in   = SRC_BUF;
                              rlen_in  = total[14:0];
                              rpos_in  = '0;
                              fpos_in  = '0;
                              phase_in = PH_FETCH;
                              result.fetch_request = 1'b1;
                              result.fetch_lba     = lba;
                              result.fetch_count   = count;
                           end
                        end
                        default: begin
                           key_in = KEY_ILLEGAL; asc_in = ASC_OPCODE; ascq_in = 8'h00;
                           phase_in = PH_STATUS;
                        end
                     endcase
                  end
               end
            end
            MODE_READ: begin
               if (phase_ff == PH_DATA && rpos_ff < rlen_ff) begin
                  if (src_ff == SRC_BUF) begin
                     result.use_ram = 1'b1;
                     ram_ctl.re     = 1'b1;
                  end else begin
                     result.read_word = const_word;
                  end
                  rpos_in = rpos_ff + 15'd2;
                  if (rpos_in >= rlen_ff) begin
                     phase_in = PH_STATUS;
                  end
               end
            end
            MODE_MEDIA: begin
               if (phase_ff == PH_FETCH && fpos_ff < rlen_ff) begin
                  ram_ctl.we = 1'b1;
                  fpos_in = fpos_ff + 15'd2;
                  if (fpos_in >= rlen_ff) begin
                     rpos_in  = '0;
                     phase_in = PH_DATA;
                  end
               end
            end
            MODE_CLEAR: chg_in = 1'b0;
            default: ;
         endcase
      end

      result.status_byte   = (phase_in == PH_DATA) ? STATUS_DRQ : STATUS_DRDY;
      result.error_flag    = key_in != 8'h00;
      result.phase_now     = phase_code(phase_in);
      result.bytes_left    = (rlen_in > rpos_in) ? 14'(rlen_in - rpos_in) : 14'd0;
      result.disc_changed  = chg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         src_ff   <= SRC_BUF;
         fill_ff  <= '0;
         rlen_ff  <= '0;
         rpos_ff  <= '0;
         fpos_ff  <= '0;
         key_ff   <= '0;
         asc_ff   <= '0;
         ascq_ff  <= '0;
         chg_ff   <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         src_ff   <= src_in;
         fill_ff  <= fill_in;
         rlen_ff  <= rlen_in;
         rpos_ff  <= rpos_in;
         fpos_ff  <= fpos_in;
         key_ff   <= key_in;
         asc_ff   <= asc_in;
         ascq_ff  <= ascq_in;
         chg_ff   <= chg_in;
      end
      pkt_ff  <= pkt_in;
      last_ff <= last_in;
   end

`ifndef SYNTHESIS
   a_fetch_only_from_packet: assert property (@(posedge clock) disable iff (reset)
      result.fetch_request |-> (phase_ff == PH_PACKET && phase_in == PH_FETCH))
      else $error("fetch raised outside packet decode");
   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.we && ram_ctl.re))
      else $error("buffer read and write in one item");
   a_read_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (rpos_ff < rlen_ff))
      else $error("data phase with no bytes left");
`endif

endmodule

[rtl/atapi_cdrom_packet_device.sv]
// ----------------------------------------------------------------------------
// atapi_cdrom_packet_device
// ATAPI CD-ROM packet device with a media-fed reply buffer.
// ----------------------------------------------------------------------------
// Each host bus access enters as one item on the req_ channel (mode and word)
// and yields exactly one item on the rsp_ channel, carrying the data word,
// status byte, phase and fetch request. A READ(10) raises fetch_request; the
// media words are then written back with mode 4 before the data phase.
// The csr_ channel writes media_present (0), sector_count (1) and
// capacity_bytes (2); it is always ready. The user must write it only while
// the block is idle, which the block does not enforce. Throughput is one item
// per cycle while the receiver does not stall. An accepted item is registered
// in the middle register, with the state update and buffer RAM read, then in
// the result register. When the receiver stalls, the result holds, one further
// item is taken into the middle register, and req_stall then rises until the
// result is taken. Reset clears the command state and restores the register
// defaults; buffer and packet contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module atapi_cdrom_packet_device #(
   parameter int BUFFER_SECTORS = 4,
   parameter int PACKET_BYTES   = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_word_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_word,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_status_byte,
   output logic        rsp_error_flag,
   output logic [2:0]  rsp_phase_now,
   output logic [13:0] rsp_bytes_left,
   output logic        rsp_disc_changed,
   output logic        rsp_fetch_request,
   output logic [31:0] rsp_fetch_lba,
   output logic [15:0] rsp_fetch_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import acpd_pkg::*;

   localparam int DEPTH  = BUFFER_SECTORS * SECTOR_BYTES / 2;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [1:0] CSR_MEDIA    = 2'd0;
   localparam logic [1:0] CSR_SECTORS  = 2'd1;
   localparam logic [1:0] CSR_CAPACITY = 2'd2;

   logic        media_ff;
   logic [31:0] sectors_ff;
   logic [13:0] capacity_ff;

   logic              accept, out_load;
   result_type        core_res, mid_ff, out_ff, out_in;
   logic              mid_valid_ff, mid_valid_in, out_valid_ff, out_valid_in;
   ram_ctl_type       ram_ctl;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         media_ff    <= 1'b1;
         sectors_ff  <= '0;
         capacity_ff <= 14'd8192;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MEDIA:    media_ff    <= csr_wdata[0];
            CSR_SECTORS:  sectors_ff  <= csr_wdata;
            CSR_CAPACITY: capacity_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   assign out_load  = mid_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = mid_valid_ff && !out_load;
   assign accept    = req_valid && !req_stall;

   acpd_core #(
      .BUFFER_SECTORS(BUFFER_SECTORS),
      .PACKET_BYTES  (PACKET_BYTES),
      .ADDR_W        (ADDR_W)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .word_in       (req_word_in),
      .media_present (media_ff),
      .sector_count  (sectors_ff),
      .capacity_bytes(capacity_ff),
      .result        (core_res),
      .ram_ctl       (ram_ctl),
      .ram_waddr     (ram_waddr),
      .ram_raddr     (ram_raddr)
   );

   acpd_ram #(
      .WIDTH(16),
      .DEPTH(DEPTH)
   ) u_buffer (
      .clock  (clock),
      .wr_en  (ram_ctl.we),
      .wr_addr(ram_waddr),
      .wr_data(req_word_in),
      .rd_en  (ram_ctl.re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // The RAM read data stays put while the middle item waits, as no new item
   // can be accepted until it moves on.
   always_comb begin
      out_in = mid_ff;
      if (mid_ff.use_ram) begin
         out_in.read_word = ram_rdata;
      end
      mid_valid_in = accept || (mid_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         mid_ff <= core_res;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_word     = out_ff.read_word;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_status_byte   = out_ff.status_byte;
   assign rsp_error_flag    = out_ff.error_flag;
   assign rsp_phase_now     = out_ff.phase_now;
   assign rsp_bytes_left    = out_ff.bytes_left;
   assign rsp_disc_changed  = out_ff.disc_changed;
   assign rsp_fetch_request = out_ff.fetch_request;
   assign rsp_fetch_lba     = out_ff.fetch_lba;
   assign rsp_fetch_count   = out_ff.fetch_count;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mid_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a waiting item");
   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_load) |=> (mid_valid_ff && $stable(mid_ff)))
      else $error("middle item lost while waiting");
   a_rdata_held: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !out_load && mid_ff.use_ram) |=> $stable(ram_rdata))
      else $error("buffer data changed under a waiting item");
`endif

endmodule

[tb/tb_atapi_cdrom_packet_device.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atapi_cdrom_packet_device
// Self-checking bench for the packet device. A directed table of commands is
// followed by random command sequences with random media data. Every result
// is checked against a behavioural model held in the bench, or against the table's own answers for the directed table.
// ----------------------------------------------------------------------------
module tb_atapi_cdrom_packet_device;
   import acpd_pkg::*;

   localparam int BUF_SECTORS = 4;
   localparam int BUF_BYTES   = BUF_SECTORS * SECTOR_BYTES;
   localparam int BUF_WORDS   = BUF_BYTES / 2;
   localparam logic [2:0] MODE_POLL = 3'd6;
   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam logic [1:0] REG_MEDIA = 2'd0;
   localparam logic [1:0] REG_SECTORS = 2'd1;
   localparam logic [1:0] REG_CAPACITY = 2'd2;

   typedef struct packed {
      logic [15:0] read_word;
      logic        accepted;
      logic [7:0]  status_byte;
      logic        error_flag;
      logic [2:0]  phase_now;
      logic [13:0] bytes_left;
      logic        disc_changed;
      logic        fetch_request;
      logic [31:0] fetch_lba;
      logic [15:0] fetch_count;
   } answer_type;

   typedef struct {
      logic [2:0]  mode;
      logic [15:0] word;
      logic        typed;
      answer_type  ans;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic [2:0] req_mode = 0;
   logic [15:0] req_word_in = 0;
   logic rsp_stall = 0;
   logic csr_valid = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic [15:0] rsp_read_word;
   logic rsp_accepted, rsp_error_flag, rsp_disc_changed, rsp_fetch_request;
   logic [7:0] rsp_status_byte;
   logic [2:0] rsp_phase_now;
   logic [13:0] rsp_bytes_left;
   logic [31:0] rsp_fetch_lba;
   logic [15:0] rsp_fetch_count;

   atapi_cdrom_packet_device dut (.*);

   always #10 clock = ~clock;

   // Model state
   logic        m_present;
   logic [31:0] m_sectors;
   logic [13:0] m_capacity;
   logic [2:0]  m_phase;
   logic [7:0]  m_packet [12];
   int unsigned m_fill, m_len, m_rpos, m_fpos;
   logic [15:0] m_buf [BUF_WORDS];
   logic [7:0]  m_key, m_asc, m_ascq;
   logic        m_changed;

   answer_type expected_answers[$];
   int failures = 0;
   int sender_idle = 23, receiver_idle = 78;
   logic hold_receiver = 0;

   function automatic void model_soft_reset();
      m_phase = PH_CODE_IDLE; m_fill = 0; m_len = 0; m_rpos = 0; m_fpos = 0;
      m_key = 0; m_asc = 0; m_ascq = 0; m_changed = 1;
   endfunction

   function automatic void load_bytes(input logic [7:0] b [], input int n);
      for (int i = 0; i < n; i += 2)
         m_buf[i / 2] = {b[i], (i + 1 < n) ? b[i + 1] : 8'h00};
      m_len = n; m_rpos = 0; m_phase = PH_CODE_DATA;
   endfunction

   function automatic void run_command(output logic fr, output logic [31:0] fl,
                                       output logic [15:0] fc);
      logic [7:0] r [];
      logic [31:0] lba, cnt, total, cap, last;
      logic [15:0] w;
      fr = 0; fl = 0; fc = 0;
      case (m_packet[0])
         OP_INQUIRY: begin
            r = new[36];
            for (int i = 0; i < 18; i++) begin
               w = inquiry_word(i[4:0]);
               r[2*i] = w[15:8];
               r[2*i+1] = w[7:0];
            end
            load_bytes(r, 36);
         end
         OP_TEST_READY: begin
            if (!m_present) begin
               m_key = KEY_NOT_READY; m_asc = ASC_NO_MEDIUM; m_ascq = 0;
            end
            m_phase = PH_CODE_STATUS;
         end
         OP_SENSE: begin
            r = new[18];
            foreach (r[i]) r[i] = 0;
            r[0] = 8'h70; r[2] = m_key; r[7] = 8'd10; r[12] = m_asc; r[13] = m_ascq;
            load_bytes(r, 18);
         end
         OP_CAPACITY: begin
            r = new[8];
            last = m_sectors - 1;
            {r[0], r[1], r[2], r[3]} = last;
            {r[4], r[5], r[6], r[7]} = SECTOR_BYTES;
            load_bytes(r, 8);
         end
         OP_READ10: begin
            lba = {m_packet[2], m_packet[3], m_packet[4], m_packet[5]};
            cnt = {m_packet[7], m_packet[8]};
            total = cnt * SECTOR_BYTES;
            cap = (m_capacity < BUF_BYTES) ? m_capacity : BUF_BYTES;
            if (total > cap || !m_present ||
                  {1'b0, lba} + {1'b0, cnt} > {1'b0, m_sectors}) begin
               m_key = KEY_ILLEGAL; m_asc = ASC_RANGE; m_ascq = 0;
               m_phase = PH_CODE_STATUS;
            end else if (cnt == 0) begin
               m_phase = PH_CODE_STATUS;
            end else begin
               m_len = total; m_rpos = 0; m_fpos = 0; m_phase = PH_CODE_FETCH;
               fr = 1; fl = lba; fc = cnt[15:0];
            end
         end
         default: begin
            m_key = KEY_ILLEGAL; m_asc = ASC_OPCODE; m_ascq = 0;
            m_phase = PH_CODE_STATUS;
         end
      endcase
   endfunction

   function automatic answer_type predict_answer(input logic [2:0] mode,
                                                 input logic [15:0] word);
      answer_type a;
      a = '0;
      case (mode)
         MODE_RESET: model_soft_reset();
         MODE_BEGIN: begin
            m_phase = PH_CODE_PACKET; m_fill = 0;
         end
         MODE_PACKET: if (m_phase == PH_CODE_PACKET) begin
            a.accepted = 1;
            m_packet[m_fill] = word[15:8];
            m_packet[m_fill + 1] = word[7:0];
            m_fill += 2;
            if (m_fill >= 12) begin
               m_fill = 0;
               run_command(a.fetch_request, a.fetch_lba, a.fetch_count);
            end
         end
         MODE_READ: if (m_phase == PH_CODE_DATA && m_rpos < m_len) begin
            a.read_word = m_buf[m_rpos / 2];
            m_rpos += 2;
            if (m_rpos >= m_len) m_phase = PH_CODE_STATUS;
         end
         MODE_MEDIA: if (m_phase == PH_CODE_FETCH && m_fpos < m_len) begin
            m_buf[m_fpos / 2] = word;
            m_fpos += 2;
            if (m_fpos >= m_len) begin
               m_rpos = 0; m_phase = PH_CODE_DATA;
            end
         end
         MODE_CLEAR: m_changed = 0;
         default: ;
      endcase
      a.status_byte = (m_phase == PH_CODE_DATA) ? STATUS_DRQ : STATUS_DRDY;
      a.error_flag = (m_key != 0);
      a.phase_now = m_phase;
      a.bytes_left = (m_len > m_rpos) ? 14'(m_len - m_rpos) : 14'd0;
      a.disc_changed = m_changed;
      return a;
   endfunction

   // Drives one item and waits until it is taken; valid stays high afterwards
   // until the next idle cycle or a drain.
   task automatic send_item(input logic [2:0] mode, input logic [15:0] word);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_mode <= mode; req_word_in <= word;
      expected_answers.push_back(predict_answer(mode, word));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet(input logic [7:0] op, input logic [31:0] lba,
                              input logic [15:0] cnt);
      send_item(MODE_BEGIN, 16'($urandom));
      send_item(MODE_PACKET, {op, 8'h00});
      send_item(MODE_PACKET, lba[31:16]);
      send_item(MODE_PACKET, lba[15:0]);
      send_item(MODE_PACKET, {8'h00, cnt[15:8]});
      send_item(MODE_PACKET, {cnt[7:0], 8'h00});
      send_item(MODE_PACKET, 16'h0000);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MEDIA:    m_present = val[0];
         REG_SECTORS:  m_sectors = val;
         default:      m_capacity = val[13:0];
      endcase
   endtask

   // Result checker and receiver stalls.
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_read_word, rsp_accepted, rsp_status_byte, rsp_error_flag,
                rsp_phase_now, rsp_bytes_left, rsp_disc_changed,
                rsp_fetch_request, rsp_fetch_lba, rsp_fetch_count};
         if (expected_answers.size() == 0) begin
            $display("%t unexpected result %h", $time, got);
            failures++;
         end else begin
            want = expected_answers.pop_front();
            if (got !== want) begin
               $display("%t mismatch expected %h actual %h", $time, want, got);
               failures++;
            end
         end
      end
      rsp_stall <= hold_receiver || ($urandom_range(99) < receiver_idle);
   end

   row_type directed [$];

   task automatic add_row(input logic [2:0] mode, input logic [15:0] word,
                          input logic typed, input answer_type a);
      row_type r;
      r.mode = mode; r.word = word; r.typed = typed; r.ans = a;
      directed.push_back(r);
   endtask

   task automatic random_command();
      int pick;
      logic [15:0] cnt;
      logic [31:0] lba;
      pick = $urandom_range(99);
      if (pick < 45) begin
         cnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
         lba = ($urandom_range(7) == 0) ? $urandom : $urandom_range(40);
         send_packet(OP_READ10, lba, cnt);
         // A full sector fill is long; here the fill is left partial and the
         // next command aborts it.
         repeat ($urandom_range(6)) send_item(MODE_MEDIA, 16'($urandom));
         if ($urandom_range(1) == 0) send_item(MODE_READ, 16'($urandom));
      end else if (pick < 80) begin
         case ($urandom_range(4))
            0: send_packet(OP_INQUIRY, $urandom, 16'($urandom));
            1: send_packet(OP_SENSE, $urandom, 16'($urandom));
            2: send_packet(OP_CAPACITY, $urandom, 16'($urandom));
            3: send_packet(OP_TEST_READY, $urandom, 16'($urandom));
            default: send_packet(8'($urandom), $urandom, 16'($urandom));
         endcase
         while (m_phase == PH_CODE_DATA && $urandom_range(19) != 0)
            send_item(MODE_READ, 16'($urandom));
      end else begin
         send_item(3'($urandom_range(7)), 16'($urandom));
      end
   endtask

   initial begin
      answer_type a;
      repeat (3) @(posedge clock);
      reset <= 0;
      m_present = 1; m_sectors = 0; m_capacity = 14'd8192;
      model_soft_reset();
      foreach (m_buf[i]) m_buf[i] = 0;
      foreach (m_packet[i]) m_packet[i] = 0;

      // Directed table: after reset, stray accesses, then an unknown opcode and a reset.
      a = '0; a.status_byte = STATUS_DRDY; a.disc_changed = 1;
      add_row(MODE_POLL, 16'hFFFF, 1, a);
      add_row(MODE_SPARE, 16'h0000, 1, a);
      add_row(MODE_PACKET, 16'hFFFF, 1, a);
      add_row(MODE_READ, 16'h1234, 1, a);
      add_row(MODE_MEDIA, 16'hFFFF, 1, a);
      a.disc_changed = 0;
      add_row(MODE_CLEAR, 16'h0000, 1, a);
      a.phase_now = PH_CODE_PACKET;
      add_row(MODE_BEGIN, 16'h0000, 1, a);
      a.accepted = 1;
      add_row(MODE_PACKET, 16'hFF00, 1, a);
      for (int i = 0; i < 4; i++) add_row(MODE_PACKET, 16'hFFFF, 1, a);
      a.phase_now = PH_CODE_STATUS; a.error_flag = 1;
      add_row(MODE_PACKET, 16'h0000, 1, a);
      a = '0; a.status_byte = STATUS_DRDY; a.disc_changed = 1;
      add_row(MODE_RESET, 16'hFFFF, 1, a);
      foreach (directed[i]) begin
         send_item(directed[i].mode, directed[i].word);
         if (directed[i].typed) expected_answers[$] = directed[i].ans;
      end
      // Capacity, read, sense and inquiry opcodes, sticky sense, empty-disc capacity, zero-length read.
      send_packet(OP_CAPACITY, 32'd0, 16'd0);
      repeat (4) send_item(MODE_READ, 16'd0);
      send_packet(OP_READ10, 32'd0, 16'd0);
      send_packet(OP_READ10, 32'd0, 16'd1);
      send_packet(OP_SENSE, 32'd0, 16'd0);
      repeat (9) send_item(MODE_READ, 16'd0);
      send_packet(OP_INQUIRY, 32'd0, 16'd0);
      repeat (19) send_item(MODE_READ, 16'd0);
      drain();

      // One complete sector fill, then media words read back from the buffer.
      write_reg(REG_SECTORS, 32'd8);
      csr_valid <= 0;
      send_packet(OP_READ10, 32'd3, 16'd1);
      repeat (SECTOR_BYTES / 2) send_item(MODE_MEDIA, 16'($urandom));
      repeat (24) send_item(MODE_READ, 16'd0);
      send_item(MODE_RESET, 16'd0);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin sender_idle = 78; receiver_idle = 23; end
         if (phase == 4) begin sender_idle = 0; receiver_idle = 0; end
         drain();
         write_reg(REG_MEDIA, (phase == 3) ? 0 : 1);
         write_reg(REG_SECTORS, (phase == 5) ? 32'hFFFF_FFFF : $urandom_range(64));
         write_reg(REG_CAPACITY, (phase == 1) ? 0 :
                   (phase == 2) ? 32'h3FFF : (phase == 4) ? 4096 : 8192);
         csr_valid <= 0;
         if (phase == 4) begin
            send_item(MODE_RESET, 16'd0);
            send_packet(OP_TEST_READY, 32'd0, 16'd0);
            hold_receiver <= 1;
            fork
               begin repeat (60) @(posedge clock); hold_receiver <= 0; end
               repeat (8) send_item(MODE_POLL, 16'($urandom));
            join
            drain();
         end
         for (int k = 0; k < 3; k++) random_command();
         if ($urandom_range(3) == 0) send_item(MODE_RESET, 16'($urandom));
      end
      drain();
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
